// ===== hdl/httok_pkg.sv =====
`default_nettype none
package httok_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ENTRY_W = 6;
   localparam int unsigned RSP_TDATA_W = 32;

   // Register indexes on the configuration port.
   localparam logic CSR_METHOD_MAX_LEN = 1'b0;
   localparam logic CSR_FIELD_MAX_LEN  = 1'b1;

   localparam logic [3:0]        METHOD_MAX_LEN_RST = 4'd10;
   localparam logic [BYTE_W-1:0] FIELD_MAX_LEN_RST  = 8'd100;

   // Delimiter bytes.
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_METHOD = 2'd0,
      KIND_URL    = 2'd1,
      KIND_KEY    = 2'd2,
      KIND_VALUE  = 2'd3
   } kind_type;

   // One result record as it travels from the front through the queue.
   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      logic [BYTE_W-1:0]   idx;
      logic [ENTRY_W-1:0]  entry;
      logic                tok_end;
      logic                trunc;
      logic                tme;
      logic                done;
   } rec_type;

endpackage
`default_nettype wire

// ===== hdl/httok_front.sv =====
`default_nettype none
module httok_front
   import httok_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [BYTE_W-1:0] csr_wdata,
   output      logic              push,
   output      rec_type           push_rec
);

   typedef enum logic [8:0] {
      PH_METHOD = 9'b000000001,
      PH_URL    = 9'b000000010,
      PH_SKIP   = 9'b000000100,
      PH_LINE   = 9'b000001000,
      PH_KEY    = 9'b000010000,
      PH_SPACE  = 9'b000100000,
      PH_VALUE  = 9'b001000000,
      PH_DROP   = 9'b010000000,
      PH_BLANK  = 9'b100000000
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    len_ff, len_in;
   logic [ENTRY_W-1:0]   cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [3:0]           method_max_ff;
   logic [BYTE_W-1:0]    field_max_ff;

   logic                 is_full;
   logic                 do_tok, do_end, do_key, do_val, tok_tme;
   kind_type             tok_kind;
   logic [BYTE_W-1:0]    tok_limit;
   logic [ENTRY_W-1:0]   tok_entry;

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      push      = 1'b0;
      push_rec  = '0;
      is_full   = (cnt_ff >= ENTRY_W'(MAX_ENTRIES));
      do_tok    = 1'b0;
      do_end    = 1'b0;
      do_key    = 1'b0;
      do_val    = 1'b0;
      tok_kind  = KIND_METHOD;
      tok_limit = field_max_ff;
      tok_entry = '0;
      tok_tme   = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_METHOD: begin
               tok_limit = {4'b0, method_max_ff};
               if (in_byte == CH_SPACE) begin
                  phase_in = PH_URL;
                  do_end   = 1'b1;
               end else begin
                  do_tok = 1'b1;
               end
            end
            PH_URL: begin
               tok_kind = KIND_URL;
               if (in_byte == CH_SPACE || in_byte == CH_QMARK) begin
                  phase_in = PH_SKIP;
                  do_end   = 1'b1;
               end else begin
                  do_tok = 1'b1;
               end
            end
            PH_SKIP: begin
               if (in_byte == CH_LF) phase_in = PH_LINE;
            end
            PH_LINE: begin
               if (in_byte == CH_CR) phase_in = PH_BLANK;
               else                  do_key   = 1'b1;
            end
            PH_KEY:   do_key = 1'b1;
            PH_SPACE: begin
               if (in_byte == CH_SPACE) phase_in = PH_VALUE;
               else                     do_val   = 1'b1;
            end
            PH_VALUE: do_val = 1'b1;
            PH_DROP:  phase_in = PH_LINE;
            PH_BLANK: begin
               push           = 1'b1;
               push_rec.entry = cnt_ff;
               push_rec.done  = 1'b1;
               phase_in       = PH_METHOD;
               cnt_in         = '0;
               len_in         = '0;
               ovf_in         = 1'b0;
            end
            default: phase_in = PH_METHOD;
         endcase
      end

      // Header key: closes at the colon.
      if (do_key) begin
         tok_kind  = KIND_KEY;
         tok_entry = cnt_ff;
         tok_tme   = is_full;
         if (in_byte == CH_COLON) begin
            phase_in = PH_SPACE;
            do_end   = 1'b1;
         end else begin
            phase_in = PH_KEY;
            do_tok   = 1'b1;
         end
      end

      // Header value: closes at CR, then count the entry unless full.
      if (do_val) begin
         tok_kind  = KIND_VALUE;
         tok_entry = cnt_ff;
         tok_tme   = is_full;
         if (in_byte == CH_CR) begin
            phase_in = PH_DROP;
            do_end   = 1'b1;
            if (!is_full) cnt_in = ENTRY_W'(cnt_ff + 1'b1);
         end else begin
            phase_in = PH_VALUE;
            do_tok   = 1'b1;
         end
      end

      if (do_tok) begin
         if (len_ff >= tok_limit) begin
            ovf_in = 1'b1;
         end else begin
            len_in         = BYTE_W'(len_ff + 1'b1);
            push           = !tok_tme;
            push_rec.kind  = tok_kind;
            push_rec.data  = in_byte;
            push_rec.idx   = len_ff;
            push_rec.entry = tok_entry;
         end
      end

      if (do_end) begin
         push             = 1'b1;
         push_rec.kind    = tok_kind;
         push_rec.idx     = len_ff;
         push_rec.entry   = tok_entry;
         push_rec.tok_end = 1'b1;
         push_rec.trunc   = ovf_ff;
         push_rec.tme     = tok_tme;
         len_in           = '0;
         ovf_in           = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_METHOD;
         len_ff        <= '0;
         cnt_ff        <= '0;
         ovf_ff        <= 1'b0;
         method_max_ff <= METHOD_MAX_LEN_RST;
         field_max_ff  <= FIELD_MAX_LEN_RST;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_METHOD_MAX_LEN: method_max_ff <= csr_wdata[3:0];
               CSR_FIELD_MAX_LEN:  field_max_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/httok_queue.sv =====
`default_nettype none
module httok_queue
   import httok_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rec_type push_rec,
   input  wire logic    pop,
   output      logic    full,
   output      logic    not_empty,
   output      rec_type head_rec
);

   rec_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_rec  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop)      cnt_in = (QPTR_W+1)'(cnt_ff + 1'b1);
      else if (pop && !push) cnt_in = (QPTR_W+1)'(cnt_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/httok_back.sv =====
`default_nettype none
module httok_back
   import httok_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   not_empty,
   input  wire rec_type                head_rec,
   output      logic                   pop,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,
   output      logic [1:0]             rsp_tuser,
   output      logic                   rsp_tlast
);

   logic                   valid_ff, valid_in;
   logic [RSP_TDATA_W-1:0] tdata_ff, tdata_in;
   logic [1:0]             tuser_ff, tuser_in;
   logic                   tlast_ff, tlast_in;
   logic [BYTE_W-1:0]      out_byte;
   logic                   is_upper;

   // Fold key bytes to lower case; only 'A'..'Z' move.
   always_comb begin
      is_upper = (head_rec.data >= CH_UPPER_A) && (head_rec.data <= CH_UPPER_Z);
      out_byte = head_rec.data;
      if (head_rec.kind == KIND_KEY && is_upper)
         out_byte = BYTE_W'(head_rec.data + CASE_OFFSET);
   end

   // Load the output register when it is empty or being drained.
   assign pop = not_empty && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      tdata_in = tdata_ff;
      tuser_in = tuser_ff;
      tlast_in = tlast_ff;
      if (pop) begin
         valid_in = 1'b1;
         tdata_in = {7'b0, head_rec.tme, head_rec.trunc, head_rec.tok_end,
                     head_rec.entry, head_rec.idx, out_byte};
         tuser_in = head_rec.kind;
         tlast_in = head_rec.done;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      tdata_ff <= tdata_in;
      tuser_ff <= tuser_in;
      tlast_ff <= tlast_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;
   assign rsp_tlast  = tlast_ff;

endmodule
`default_nettype wire

// ===== hdl/http_header_tokenizer_top.sv =====
// HTTP request header tokenizer. Feed the request text one byte per req_
// transfer; the block accepts a new byte every cycle as long as its
// four-entry result queue has room, so the sustained rate is one byte per
// clock. The rate is set by the byte parser's registered phase update; a
// stalled rsp_ side only holds req_tready low once the queue and the output
// register are full. A byte yields zero or one result transfer: a token
// byte, a token end marker, or a done marker when a blank line closes the
// header block (the parser then rearms for the next request). Results carry
// token_kind in rsp_tuser (0 method, 1 URL, 2 key, 3 value) and header_done
// on rsp_tlast. Key bytes come out lower-cased. Tokens longer than their
// limit are cut and flagged on the end marker; headers beyond MAX_ENTRIES
// give only end markers flagged too_many_entries.
// Write limits through csr_ only while the block is idle.
`default_nettype none
module http_header_tokenizer_top
   import httok_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // in_byte[7:0]
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,
   // data_byte[7:0], byte_index[15:8], entry_index[21:16], token_end[22],
   // truncated[23], too_many_entries[24], zero fill [31:25]
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,
   // token_kind[1:0]
   output      logic [1:0]             rsp_tuser,
   // header_done
   output      logic                   rsp_tlast,
   // 0 method_max_len, 1 field_max_len
   input  wire logic                   csr_wr_en,
   input  wire logic                   csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata
);

   logic    q_full, q_not_empty, q_push, q_pop, req_accept;
   rec_type push_rec, head_rec;

   // Accept a byte whenever the queue can take its result.
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   // Front: classify bytes and advance the parse phase.
   httok_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .in_byte   (req_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (q_push),
      .push_rec  (push_rec)
   );

   // Queue decoupling parser from output stalls.
   httok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (push_rec),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_rec  (head_rec)
   );

   // Back: fold case, pack and hold the result transfer.
   httok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (q_not_empty),
      .head_rec   (head_rec),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== hdl/httok_checker.sv =====
`default_nettype none
module httok_checker
   import httok_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]             rsp_tuser,
   input wire logic                   rsp_tlast
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Output register empties on reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Done marker carries only the entry count.
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[15:0] == 16'd0
         && rsp_tdata[24:22] == 3'd0 && rsp_tuser == KIND_METHOD)
      else $error("done marker with token content");

   // Truncation and capacity flags appear only on end markers.
   a_flags_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[22] |-> !rsp_tdata[23] && !rsp_tdata[24])
      else $error("flag on a token byte");

   // Key bytes never leave in upper case.
   a_key_folded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_KEY && !rsp_tdata[22]
         |-> !(rsp_tdata[7:0] >= CH_UPPER_A && rsp_tdata[7:0] <= CH_UPPER_Z))
      else $error("upper-case key byte");

endmodule

bind http_header_tokenizer_top httok_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
